/* rtl/core/rtc_seconds_alarm_registers_assert.svh */
// Assertion macros shared by the RTC register block.
`ifndef RTC_SECONDS_ALARM_REGISTERS_ASSERT_SVH
`define RTC_SECONDS_ALARM_REGISTERS_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/rsa_pkg.sv */
// Types and constants for the RTC seconds/alarm register block.
package rsa_pkg;

  // Request kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // Register offsets (low two bits dropped before decode)
  localparam logic [5:0] REG_CTRL      = 6'h00;
  localparam logic [5:0] REG_SEC       = 6'h04;
  localparam logic [5:0] REG_ALARM     = 6'h08;
  localparam logic [5:0] REG_REGULATOR = 6'h0C;
  localparam logic [5:0] REG_HIBERNATE = 6'h20;
  localparam logic [5:0] REG_SCRATCH   = 6'h34;
  localparam logic [5:0] REG_WENR      = 6'h3C;

  localparam logic [31:0] UNLOCK_MAGIC = 32'h0000_A55A;
  localparam int unsigned WENR_BIT     = 31;

  // CTRL bit positions
  localparam int unsigned CTRL_WRDY  = 7;
  localparam int unsigned CTRL_SECF  = 6;
  localparam int unsigned CTRL_SECIE = 5;
  localparam int unsigned CTRL_ALF   = 4;
  localparam int unsigned CTRL_ALIE  = 3;
  localparam int unsigned CTRL_ALEN  = 2;
  localparam int unsigned CTRL_EN    = 0;

  localparam logic [15:0] DIVIDER_RESET = 16'd32767;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  address;
    logic [31:0] write_data;
  } rsa_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        write_rejected;
    logic        irq;
    logic        hibernate_request;
  } rsa_out_t;

endpackage

/* rtl/core/rtc_seconds_alarm_registers.sv */
// Real-time clock seconds counter with alarm: one request (tick, read or write) per clock,
// each producing one response. A request is held in the input register, where the timer
// and register logic update state and compute the response, then waits in the result
// register; out_valid rises when the response is loaded there and stays high until the
// consumer takes it. One request per clock is sustained while the consumer keeps taking
// responses; in_ready follows out_ready in the same cycle when both registers are full.
// The unlock-required bit is set through cfg_we/cfg_wdata.
module rtc_seconds_alarm_registers import rsa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rsa_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rsa_out_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

  logic     item_valid;
  rsa_in_t  item;
  rsa_out_t result;
  logic     advance;

  assign advance = item_valid && (!out_valid || out_ready);

  rsa_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  rsa_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .item      (item),
    .result    (result)
  );

  rsa_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .result    (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/core/rsa_in_stage.sv */
// Input register: holds one request for the register/timer stage.
module rsa_in_stage import rsa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  rsa_in_t in_data,
  input  logic    advance,
  output logic    item_valid,
  output rsa_in_t item
);

  logic    valid_r;
  rsa_in_t data_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

/* rtl/core/rsa_core.sv */
// Timer state, register file and per-request update logic.
`include "rtc_seconds_alarm_registers_assert.svh"

module rsa_core import rsa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     advance,
  input  rsa_in_t  item,
  output rsa_out_t result
);

  logic [31:0] sec_r, sec_nxt;
  logic [31:0] alarm_r, alarm_nxt;
  logic [15:0] div_r, div_nxt;
  logic [15:0] pre_r, pre_nxt;
  logic        clk_en_r, clk_en_nxt;
  logic        al_en_r, al_en_nxt;
  logic        al_flag_r, al_flag_nxt;
  logic        al_ie_r, al_ie_nxt;
  logic        sec_flag_r, sec_flag_nxt;
  logic        sec_ie_r, sec_ie_nxt;
  logic [31:0] scratch_r, scratch_nxt;
  logic        unlocked_r, unlocked_nxt;
  logic        hib_r, hib_nxt;
  logic        unlock_req_r;

  logic [5:0]  reg_addr;
  logic [31:0] rd_data;
  logic [31:0] sec_inc;
  logic        is_write;
  logic        rejected;

  assign reg_addr = {item.address[5:2], 2'b00};
  assign is_write = (item.kind == KIND_WRITE);
  assign rejected = is_write && (reg_addr != REG_WENR) && unlock_req_r && !unlocked_r;
  assign sec_inc  = sec_r + 32'd1;

  // Register read mux
  always_comb begin
    rd_data = '0;
    unique case (reg_addr)
      REG_CTRL: begin
        rd_data[CTRL_WRDY]  = 1'b1;
        rd_data[CTRL_SECF]  = sec_flag_r;
        rd_data[CTRL_SECIE] = sec_ie_r;
        rd_data[CTRL_ALF]   = al_flag_r;
        rd_data[CTRL_ALIE]  = al_ie_r;
        rd_data[CTRL_ALEN]  = al_en_r;
        rd_data[CTRL_EN]    = clk_en_r;
      end
      REG_SEC:       rd_data = sec_r;
      REG_ALARM:     rd_data = alarm_r;
      REG_REGULATOR: rd_data = {16'd0, div_r};
      REG_HIBERNATE: rd_data = {31'd0, hib_r};
      REG_SCRATCH:   rd_data = scratch_r;
      REG_WENR:      rd_data[WENR_BIT] = unlocked_r;
      default:       rd_data = '0;
    endcase
  end

  always_comb begin
    sec_nxt      = sec_r;
    alarm_nxt    = alarm_r;
    div_nxt      = div_r;
    pre_nxt      = pre_r;
    clk_en_nxt   = clk_en_r;
    al_en_nxt    = al_en_r;
    al_flag_nxt  = al_flag_r;
    al_ie_nxt    = al_ie_r;
    sec_flag_nxt = sec_flag_r;
    sec_ie_nxt   = sec_ie_r;
    scratch_nxt  = scratch_r;
    unlocked_nxt = unlocked_r;
    hib_nxt      = hib_r;

    case (item.kind)
      KIND_TICK: begin
        if (clk_en_r) begin
          if (pre_r >= div_r) begin
            pre_nxt      = '0;
            sec_nxt      = sec_inc;
            sec_flag_nxt = 1'b1;
            // alarm only compared on the second boundary
            if (al_en_r && (sec_inc == alarm_r)) begin
              al_flag_nxt = 1'b1;
            end
          end else begin
            pre_nxt = pre_r + 16'd1;
          end
        end
      end
      KIND_WRITE: begin
        if (reg_addr == REG_WENR) begin
          if (item.write_data == UNLOCK_MAGIC) begin
            unlocked_nxt = 1'b1;
          end
        end else if (!rejected) begin
          unlocked_nxt = 1'b0;
          unique case (reg_addr)
            REG_CTRL: begin
              // flags: 0 clears, 1 keeps
              if (!item.write_data[CTRL_SECF]) sec_flag_nxt = 1'b0;
              if (!item.write_data[CTRL_ALF])  al_flag_nxt  = 1'b0;
              sec_ie_nxt = item.write_data[CTRL_SECIE];
              al_ie_nxt  = item.write_data[CTRL_ALIE];
              al_en_nxt  = item.write_data[CTRL_ALEN];
              clk_en_nxt = item.write_data[CTRL_EN];
            end
            REG_SEC: begin
              sec_nxt = item.write_data;
              pre_nxt = '0;
            end
            REG_ALARM:     alarm_nxt   = item.write_data;
            REG_REGULATOR: div_nxt     = item.write_data[15:0];
            REG_HIBERNATE: hib_nxt     = hib_r | item.write_data[0];
            REG_SCRATCH:   scratch_nxt = item.write_data;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign result.read_data         = (item.kind == KIND_READ) ? rd_data : '0;
  assign result.write_rejected    = rejected;
  assign result.irq               = (sec_flag_nxt && sec_ie_nxt) || (al_flag_nxt && al_ie_nxt);
  assign result.hibernate_request = hib_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r        <= '0;
      alarm_r      <= '0;
      div_r        <= DIVIDER_RESET;
      pre_r        <= '0;
      clk_en_r     <= 1'b1;
      al_en_r      <= 1'b0;
      al_flag_r    <= 1'b0;
      al_ie_r      <= 1'b0;
      sec_flag_r   <= 1'b0;
      sec_ie_r     <= 1'b0;
      scratch_r    <= '0;
      unlocked_r   <= 1'b0;
      hib_r        <= 1'b0;
      unlock_req_r <= 1'b0;
    end else begin
      if (advance) begin
        sec_r      <= sec_nxt;
        alarm_r    <= alarm_nxt;
        div_r      <= div_nxt;
        pre_r      <= pre_nxt;
        clk_en_r   <= clk_en_nxt;
        al_en_r    <= al_en_nxt;
        al_flag_r  <= al_flag_nxt;
        al_ie_r    <= al_ie_nxt;
        sec_flag_r <= sec_flag_nxt;
        sec_ie_r   <= sec_ie_nxt;
        scratch_r  <= scratch_nxt;
        unlocked_r <= unlocked_nxt;
        hib_r      <= hib_nxt;
      end
      if (cfg_we) begin
        unlock_req_r <= cfg_wdata;
      end
    end
  end

  `RSA_ASSERT_NOW(a_wenr_never_rejected, is_write && reg_addr == REG_WENR, !result.write_rejected, "unlock write rejected")
  `RSA_ASSERT_NEXT(a_locked_write_no_effect, advance && rejected, $stable(sec_r) && $stable(scratch_r) && $stable(alarm_r), "locked write changed state")
  `RSA_ASSERT_NEXT(a_unlock_one_shot, advance && is_write && reg_addr != REG_WENR, !unlocked_r, "unlock survived a write")
  `RSA_ASSERT_NEXT(a_hibernate_sticky, hib_r, hib_r, "hibernate latch dropped")

endmodule

/* rtl/core/rsa_out_stage.sv */
// Result register: holds one response until the consumer takes it.
module rsa_out_stage import rsa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  rsa_out_t result,
  output logic     out_valid,
  input  logic     out_ready,
  output rsa_out_t out_data
);

  logic     valid_r;
  rsa_out_t data_r;

  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule
